// ----- rtl/gdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared widths, operation codes, reset date and status types of the
// Gregorian date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int OP_W    = 2;

    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [OP_W-1:0]    op_t;

    localparam op_t OP_LOAD    = 2'd0;
    localparam op_t OP_ADVANCE = 2'd1;
    localparam op_t OP_COMPARE = 2'd2;

    localparam day_t   RESET_DAY   = 5'd1;
    localparam month_t RESET_MONTH = 4'd1;
    localparam year_t  RESET_YEAR  = 14'd1970;

    localparam month_t MONTHS_PER_YEAR = 4'd12;

    // Date one day after the held date, with the year limit flag.
    typedef struct packed {
        day_t   day;
        month_t month;
        year_t  year;
        logic   overflow;
    } next_date_t;

    // Ordering of the held date against a given date.
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_result_t;

endpackage

// ----- rtl/gdc_next_date.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_next_date
// Computes the calendar date one day after the given date, using Gregorian
// month lengths, and flags a step past the last supported year.
// ----------------------------------------------------------------------------
module gdc_next_date
    import gdc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  day_t       cur_day,
    input  month_t     cur_month,
    input  year_t      cur_year,
    output next_date_t next_date
);

    localparam logic [YEAR_W:0] MAX_YEAR_W = (YEAR_W + 1)'(MAX_YEAR);
    // Inverse of 25 modulo 2**12, and the largest multiple bound for the test.
    localparam logic [11:0] INV25      = 12'd3113;
    localparam logic [11:0] DIV25_MAX  = 12'd163;

    logic [11:0]      quarter;
    logic [11:0]      quarter_mul;
    logic             div4;
    logic             div100;
    logic             div400;
    logic             leap;
    day_t             month_len;
    logic [DAY_W:0]   day_inc;
    logic             wrap_month;
    month_t           month_inc;
    logic [YEAR_W:0]  year_inc;

    // A multiple of 4 is a multiple of 100 when its quarter is a multiple of
    // 25; an odd divisor is tested by multiplying with its modular inverse.
    // Given a multiple of 100, it is a multiple of 400 when it is one of 16.
    assign quarter     = cur_year[YEAR_W-1:2];
    assign quarter_mul = 12'(quarter * INV25);
    assign div4        = (cur_year[1:0] == 2'd0);
    assign div100      = div4 && (quarter_mul <= DIV25_MAX);
    assign div400      = div100 && (cur_year[3:0] == 4'd0);
    assign leap        = (div4 && !div100) || div400;

    always_comb begin
        case (cur_month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
            4'd2:    month_len = leap ? 5'd29 : 5'd28;
            default: month_len = 5'd0;
        endcase
    end

    assign day_inc    = {1'b0, cur_day} + 6'd1;
    assign wrap_month = (day_inc > {1'b0, month_len});
    assign month_inc  = wrap_month ? (cur_month + 4'd1) : cur_month;
    assign year_inc   = {1'b0, cur_year} + 15'd1;

    always_comb begin
        next_date.day      = wrap_month ? RESET_DAY : day_inc[DAY_W-1:0];
        next_date.month    = month_inc;
        next_date.year     = cur_year;
        next_date.overflow = 1'b0;
        if (month_inc > MONTHS_PER_YEAR) begin
            next_date.day      = RESET_DAY;
            next_date.month    = RESET_MONTH;
            next_date.year     = year_inc[YEAR_W-1:0];
            next_date.overflow = (year_inc > MAX_YEAR_W);
        end
    end

endmodule

// ----- rtl/gdc_compare.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_compare
// Orders the held date against a given date: year first, then month, then
// day, with no validity check on the given fields.
// ----------------------------------------------------------------------------
module gdc_compare
    import gdc_pkg::*;
(
    input  day_t        cur_day,
    input  month_t      cur_month,
    input  year_t       cur_year,
    input  day_t        given_day,
    input  month_t      given_month,
    input  year_t       given_year,
    output cmp_result_t result
);

    logic [YEAR_W+MONTH_W+DAY_W-1:0] cur_key;
    logic [YEAR_W+MONTH_W+DAY_W-1:0] given_key;

    assign cur_key   = {cur_year, cur_month, cur_day};
    assign given_key = {given_year, given_month, given_day};

    assign result.lt = (cur_key < given_key);
    assign result.eq = (cur_key == given_key);
    assign result.gt = !result.lt && !result.eq;

endmodule

// ----- rtl/gregorian_date_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_counter
// Holds a calendar date and serves load, advance and compare requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (s_op, s_day, s_month, s_year) with a
//   valid/ready handshake; each request gives exactly one result on the m_
//   channel. Load stores a checked date or flags range_error and keeps the
//   old one; advance returns the date before the step and moves one day on;
//   compare sets one of is_less, is_equal, is_greater.
//   A request passes one input register, then one pass through the date
//   logic into the result register, which drives m_valid and the result.
//   Throughput is one request per cycle while the receiver takes results;
//   the held date is read and written in that single pass, so back-to-back
//   requests see each other's effect.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request, after which s_ready drops until
//   the result is taken.
//   Reset (aresetn low, synchronous) empties both registers and sets the
//   held date to 1/1/1970.
// ----------------------------------------------------------------------------
module gregorian_date_counter
    import gdc_pkg::*;
#(
    parameter int MIN_YEAR = 1970,
    parameter int MAX_YEAR = 9999
) (
    input  logic   aclk,
    input  logic   aresetn,

    input  logic   s_valid,
    output logic   s_ready,
    input  op_t    s_op,
    input  day_t   s_day,
    input  month_t s_month,
    input  year_t  s_year,

    output logic   m_valid,
    input  logic   m_ready,
    output day_t   m_out_day,
    output month_t m_out_month,
    output year_t  m_out_year,
    output logic   m_is_less,
    output logic   m_is_equal,
    output logic   m_is_greater,
    output logic   m_range_error
);

    localparam year_t MIN_YEAR_W = YEAR_W'(MIN_YEAR);
    localparam year_t MAX_YEAR_W = YEAR_W'(MAX_YEAR);

    logic        in_valid_reg;
    op_t         in_op_reg;
    day_t        in_day_reg;
    month_t      in_month_reg;
    year_t       in_year_reg;

    day_t        cur_day_reg,   cur_day_next;
    month_t      cur_month_reg, cur_month_next;
    year_t       cur_year_reg,  cur_year_next;

    logic        out_valid_reg;
    day_t        out_day_reg,   out_day_next;
    month_t      out_month_reg, out_month_next;
    year_t       out_year_reg,  out_year_next;
    cmp_result_t out_cmp_reg,   out_cmp_next;
    logic        out_err_reg,   out_err_next;

    logic        step;
    logic        load_ok;
    next_date_t  next_date;
    cmp_result_t cmp_result;

    // The request in the input register moves on whenever the result
    // register is empty or being emptied.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    gdc_next_date #(
        .MAX_YEAR (MAX_YEAR)
    ) u_next_date (
        .cur_day   (cur_day_reg),
        .cur_month (cur_month_reg),
        .cur_year  (cur_year_reg),
        .next_date (next_date)
    );

    gdc_compare u_compare (
        .cur_day     (cur_day_reg),
        .cur_month   (cur_month_reg),
        .cur_year    (cur_year_reg),
        .given_day   (in_day_reg),
        .given_month (in_month_reg),
        .given_year  (in_year_reg),
        .result      (cmp_result)
    );

    assign load_ok = (in_day_reg != 5'd0) &&
                     (in_month_reg != 4'd0) && (in_month_reg <= MONTHS_PER_YEAR) &&
                     (in_year_reg >= MIN_YEAR_W) && (in_year_reg <= MAX_YEAR_W);

    always_comb begin
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        out_day_next   = cur_day_reg;
        out_month_next = cur_month_reg;
        out_year_next  = cur_year_reg;
        out_cmp_next   = '0;
        out_err_next   = 1'b0;
        case (in_op_reg)
            OP_LOAD: begin
                if (load_ok) begin
                    cur_day_next   = in_day_reg;
                    cur_month_next = in_month_reg;
                    cur_year_next  = in_year_reg;
                    out_day_next   = in_day_reg;
                    out_month_next = in_month_reg;
                    out_year_next  = in_year_reg;
                end else begin
                    out_err_next = 1'b1;
                end
            end
            OP_ADVANCE: begin
                if (next_date.overflow) begin
                    out_err_next = 1'b1;
                end else begin
                    cur_day_next   = next_date.day;
                    cur_month_next = next_date.month;
                    cur_year_next  = next_date.year;
                end
            end
            OP_COMPARE: begin
                out_cmp_next = cmp_result;
            end
            default: begin
                out_cmp_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_day_reg   <= RESET_DAY;
            cur_month_reg <= RESET_MONTH;
            cur_year_reg  <= RESET_YEAR;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
                cur_day_reg   <= cur_day_next;
                cur_month_reg <= cur_month_next;
                cur_year_reg  <= cur_year_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_op;
            in_day_reg   <= s_day;
            in_month_reg <= s_month;
            in_year_reg  <= s_year;
        end
        if (step) begin
            out_day_reg   <= out_day_next;
            out_month_reg <= out_month_next;
            out_year_reg  <= out_year_next;
            out_cmp_reg   <= out_cmp_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_day     = out_day_reg;
    assign m_out_month   = out_month_reg;
    assign m_out_year    = out_year_reg;
    assign m_is_less     = out_cmp_reg.lt;
    assign m_is_equal    = out_cmp_reg.eq;
    assign m_is_greater  = out_cmp_reg.gt;
    assign m_range_error = out_err_reg;

    // The held date always stays a date the counter can reach.
    a_month_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_month_reg != 4'd0) && (cur_month_reg <= MONTHS_PER_YEAR))
        else $error("held month out of range");

    a_day_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_day_reg != 5'd0)
        else $error("held day is zero");

    // A stalled result must not let a later request change the date.
    a_stall_holds_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(cur_day_reg) && $stable(cur_month_reg) &&
                                   $stable(cur_year_reg)))
        else $error("held date changed while the result was stalled");

    // A compare result carries exactly one ordering flag and no error.
    a_cmp_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_is_less || m_is_equal || m_is_greater)) |->
            ($onehot({m_is_less, m_is_equal, m_is_greater}) && !m_range_error))
        else $error("inconsistent compare flags");

    // The input register never drops a request while the result side is busy.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |-> !s_ready)
        else $error("input register ready while holding a stalled request");

endmodule

// ----- test/date_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_checker
// Watches both channels of the Gregorian date counter. Every accepted request
// runs through a private copy of the calendar, and the date and flags that it
// should produce are queued. Every accepted result is compared field by field
// against the oldest queued entry.
// ----------------------------------------------------------------------------
module date_checker
    import gdc_pkg::*;
#(
    parameter int MIN_YEAR = 1970,
    parameter int MAX_YEAR = 9999
) (
    input  logic   aclk,
    input  logic   aresetn,

    input  logic   s_valid,
    input  logic   s_ready,
    input  op_t    s_op,
    input  day_t   s_day,
    input  month_t s_month,
    input  year_t  s_year,

    input  logic   m_valid,
    input  logic   m_ready,
    input  day_t   m_out_day,
    input  month_t m_out_month,
    input  year_t  m_out_year,
    input  logic   m_is_less,
    input  logic   m_is_equal,
    input  logic   m_is_greater,
    input  logic   m_range_error,

    output int     mismatches,
    output int     pending
);

    typedef struct {
        day_t   day;
        month_t month;
        year_t  year;
        logic   lt;
        logic   eq;
        logic   gt;
        logic   err;
    } date_result_t;

    day_t   held_day   = RESET_DAY;
    month_t held_month = RESET_MONTH;
    year_t  held_year  = RESET_YEAR;

    date_result_t expected_dates[$];
    int error_count  = 0;
    int waiting      = 0;
    int result_index = 0;

    assign mismatches = error_count;
    assign pending    = waiting;

    function automatic bit is_leap(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_days(int m, int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Applies one request to the held date and returns the result it gives.
    task automatic apply_request(input op_t op, input day_t d, input month_t m,
                                 input year_t y, output date_result_t r);
        int next_day;
        int next_month;
        int next_year;
        r.day   = held_day;
        r.month = held_month;
        r.year  = held_year;
        r.lt    = 1'b0;
        r.eq    = 1'b0;
        r.gt    = 1'b0;
        r.err   = 1'b0;
        case (op)
            OP_LOAD: begin
                if (d >= 1 && m >= 1 && m <= MONTHS_PER_YEAR &&
                    y >= MIN_YEAR && y <= MAX_YEAR) begin
                    held_day   = d;
                    held_month = m;
                    held_year  = y;
                end else begin
                    r.err = 1'b1;
                end
                // A load reports the date held after it.
                r.day   = held_day;
                r.month = held_month;
                r.year  = held_year;
            end
            OP_ADVANCE: begin
                next_day   = int'(held_day) + 1;
                next_month = int'(held_month);
                next_year  = int'(held_year);
                // A day beyond the month length, left by a loose load, also rolls over.
                if (next_day > month_days(next_month, next_year)) begin
                    next_day   = 1;
                    next_month = next_month + 1;
                end
                if (next_month > int'(MONTHS_PER_YEAR)) begin
                    next_day   = 1;
                    next_month = 1;
                    next_year  = next_year + 1;
                end
                if (next_year > MAX_YEAR) begin
                    r.err = 1'b1;
                end else begin
                    held_day   = day_t'(next_day);
                    held_month = month_t'(next_month);
                    held_year  = year_t'(next_year);
                end
            end
            OP_COMPARE: begin
                if (held_year != y) begin
                    r.lt = held_year < y;
                end else if (held_month != m) begin
                    r.lt = held_month < m;
                end else begin
                    r.lt = held_day < d;
                end
                r.eq = held_year == y && held_month == m && held_day == d;
                r.gt = !r.lt && !r.eq;
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_index, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        date_result_t want;
        if (!aresetn) begin
            held_day   = RESET_DAY;
            held_month = RESET_MONTH;
            held_year  = RESET_YEAR;
            expected_dates.delete();
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_op, s_day, s_month, s_year, want);
                expected_dates.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end else begin
                    want = expected_dates.pop_front();
                    check_field("out_day", int'(m_out_day), int'(want.day));
                    check_field("out_month", int'(m_out_month), int'(want.month));
                    check_field("out_year", int'(m_out_year), int'(want.year));
                    check_field("is_less", int'(m_is_less), int'(want.lt));
                    check_field("is_equal", int'(m_is_equal), int'(want.eq));
                    check_field("is_greater", int'(m_is_greater), int'(want.gt));
                    check_field("range_error", int'(m_range_error), int'(want.err));
                end
                result_index++;
            end
        end
        waiting = expected_dates.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load, advance, compare and unused requests into the Gregorian date counter
// with bursty requests and a stalling receiver, and gives the verdict from
// the failure count of the date checker.
// ----------------------------------------------------------------------------
module testbench;
    import gdc_pkg::*;

    localparam int  MIN_YEAR        = 1970;
    localparam int  MAX_YEAR        = 9999;
    localparam op_t OP_UNUSED       = 2'd3;
    localparam int  RANDOM_REQUESTS = 1400;
    localparam int  CYCLE_LIMIT     = 200000;
    localparam int  DRAIN_CYCLES    = 16;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    op_t    s_op;
    day_t   s_day;
    month_t s_month;
    year_t  s_year;
    logic   m_valid;
    logic   m_ready;
    day_t   m_out_day;
    month_t m_out_month;
    year_t  m_out_year;
    logic   m_is_less;
    logic   m_is_equal;
    logic   m_is_greater;
    logic   m_range_error;

    int mismatches;
    int pending;
    int cycle_count  = 0;
    int useful_count = 0;
    int burst_left   = 1;
    bit valid_high   = 1'b0;

    gregorian_date_counter #(
        .MIN_YEAR(MIN_YEAR),
        .MAX_YEAR(MAX_YEAR)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_day(s_day),
        .s_month(s_month),
        .s_year(s_year),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_day(m_out_day),
        .m_out_month(m_out_month),
        .m_out_year(m_out_year),
        .m_is_less(m_is_less),
        .m_is_equal(m_is_equal),
        .m_is_greater(m_is_greater),
        .m_range_error(m_range_error)
    );

    date_checker #(
        .MIN_YEAR(MIN_YEAR),
        .MAX_YEAR(MAX_YEAR)
    ) date_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_day(s_day),
        .s_month(s_month),
        .s_year(s_year),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_day(m_out_day),
        .m_out_month(m_out_month),
        .m_out_year(m_out_year),
        .m_is_less(m_is_less),
        .m_is_equal(m_is_equal),
        .m_is_greater(m_is_greater),
        .m_range_error(m_range_error),
        .mismatches(mismatches),
        .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Presents one request and holds it until accepted. At the end of a burst
    // the valid line may drop for a random gap.
    task automatic send_request(input op_t op, input int d, input int m, input int y);
        int gap;
        s_valid    <= 1'b1;
        s_op       <= op;
        s_day      <= day_t'(d);
        s_month    <= month_t'(m);
        s_year     <= year_t'(y);
        valid_high = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != OP_UNUSED) useful_count++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid    <= 1'b0;
                valid_high = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Dates that the load accepts, biased toward month and year ends and toward leap rules.
    task automatic pick_date(output int d, output int m, output int y);
        case ($urandom_range(0, 9))
            0:       y = MIN_YEAR;
            1:       y = 2000;
            2:       y = 2100;
            3:       y = MAX_YEAR;
            4:       y = MAX_YEAR - 1;
            5:       y = 4 * $urandom_range(493, 2499);
            default: y = $urandom_range(MIN_YEAR, MAX_YEAR);
        endcase
        if ($urandom_range(0, 2) == 0) begin
            m = 2;
        end else if ($urandom_range(0, 2) == 0) begin
            m = 12;
        end else begin
            m = $urandom_range(1, 12);
        end
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(26, 31);
    endtask

    task automatic run_date_walk();
        int d;
        int m;
        int y;
        int steps;
        pick_date(d, m, y);
        send_request(OP_LOAD, d, m, y);
        send_request(OP_COMPARE, d, m, y);
        steps = $urandom_range(1, 12);
        repeat (steps) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(OP_COMPARE, $urandom_range(0, 31),
                             $urandom_range(0, 1) ? m : (m % 12) + 1,
                             ($urandom_range(0, 2) == 0 && y < MAX_YEAR) ? y + 1 : y);
            end else begin
                send_request(OP_ADVANCE, $urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, MAX_YEAR));
            end
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_request(OP_LOAD, 0, $urandom_range(0, 15), $urandom_range(0, MAX_YEAR));
            1: send_request(OP_LOAD, $urandom_range(0, 31), $urandom_range(13, 15),
                            $urandom_range(0, MAX_YEAR));
            2: send_request(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 15),
                            $urandom_range(0, MIN_YEAR - 1));
            default: send_request(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                                  $urandom_range(0, 15), $urandom_range(0, MAX_YEAR));
        endcase
    endtask

    // The receiver alternates stalls, short random patterns and long open stretches.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                end
                1: begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(20, 150)) @(posedge aclk);
                end
                default: begin
                    m_ready <= 1'($urandom_range(0, 1));
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end
            endcase
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op    <= OP_LOAD;
        s_day   <= '0;
        s_month <= '0;
        s_year  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset date, then the top of the year range.
        send_request(OP_COMPARE, 1, 1, 1970);
        send_request(OP_ADVANCE, 0, 0, 0);
        send_request(OP_COMPARE, 1, 1, 1970);
        send_request(OP_COMPARE, 0, 15, MAX_YEAR);
        send_request(OP_LOAD, 31, 12, MAX_YEAR);
        send_request(OP_ADVANCE, 31, 15, 16383);
        send_request(OP_ADVANCE, 0, 0, 0);
        // Rejected loads must leave the held date alone.
        send_request(OP_LOAD, 0, 1, 2000);
        send_request(OP_LOAD, 1, 0, 2000);
        send_request(OP_LOAD, 1, 13, 2000);
        send_request(OP_LOAD, 31, 15, 2000);
        send_request(OP_LOAD, 1, 1, MIN_YEAR - 1);
        send_request(OP_LOAD, 31, 1, 0);
        // Leap rules: divisible by 400, century, and a day loaded past February.
        send_request(OP_LOAD, 28, 2, 2000);
        send_request(OP_ADVANCE, 0, 0, 0);
        send_request(OP_ADVANCE, 0, 0, 0);
        send_request(OP_LOAD, 28, 2, 2100);
        send_request(OP_ADVANCE, 0, 0, 0);
        send_request(OP_LOAD, 31, 2, 2001);
        send_request(OP_ADVANCE, 0, 0, 0);
        send_request(OP_LOAD, 31, 12, 1999);
        send_request(OP_ADVANCE, 0, 0, 0);
        send_request(OP_COMPARE, 1, 1, 2000);
        send_request(OP_UNUSED, 31, 15, MAX_YEAR);
        send_request(OP_LOAD, 1, 1, MIN_YEAR);
        send_request(OP_COMPARE, 2, 1, MIN_YEAR);

        useful_count = 0;
        while (useful_count < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 9) < 7) begin
                run_date_walk();
            end else begin
                send_noise();
            end
        end
        if (valid_high) s_valid <= 1'b0;

        // Wait on the clock first, so the checker has queued the last request.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- gregorian_date_counter.f -----
rtl/gdc_pkg.sv
rtl/gdc_next_date.sv
rtl/gdc_compare.sv
rtl/gregorian_date_counter.sv
test/date_checker.sv
test/testbench.sv
